[design/ssp_pkg.sv]
package ssp_pkg;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_LEAD   = 4'b0001,
		PH_DIGITS = 4'b0010,
		PH_SUFFIX = 4'b0100,
		PH_TRAIL  = 4'b1000
	} phase_t;

	// Running parse state for one string
	typedef struct packed {
		phase_t      phase;
		logic [63:0] acc;
		logic        err;
		logic [7:0]  sfx0;
		logic [7:0]  sfx1;
		logic [1:0]  sfx_len;
	} parse_state_t;

	localparam int unsigned SHIFT_K = 10;
	localparam int unsigned SHIFT_M = 20;
	localparam int unsigned SHIFT_G = 30;
	localparam int unsigned SHIFT_T = 40;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_Z  = 8'd90;
	localparam logic [7:0] CH_B     = 8'd98;
	localparam logic [7:0] CH_I     = 8'd105;
	localparam logic [7:0] CH_K     = 8'd107;
	localparam logic [7:0] CH_M     = 8'd109;
	localparam logic [7:0] CH_G     = 8'd103;
	localparam logic [7:0] CH_T     = 8'd116;

	localparam parse_state_t STATE_RESET = '{
		phase:   PH_LEAD,
		acc:     64'd0,
		err:     1'b0,
		sfx0:    8'd0,
		sfx1:    8'd0,
		sfx_len: 2'd0
	};

endpackage

[design/size_string_parser.sv]
// Channel  | Handshake            | Beat payload
// ---------+----------------------+--------------------------
// input    | in_valid / in_ready  | char_code[7:0], last_char
// output   | out_valid/ out_ready | size_value[63:0], size_ok
//
// One character beat is taken per cycle while no result is stalled; the
// per-character update (times ten plus digit, compare against 2^64) is
// combinational on the parse state. A final beat passes through the input,
// snapshot and result registers. Reset returns the parser to the leading
// whitespace phase with no beats held. While a result waits on out_ready the
// pipeline holds, and in_ready drops then only if the input register is full.
module size_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] size_value,
	output logic        size_ok
);

	logic                  en;
	logic                  v_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	ssp_pkg::parse_state_t st_q;
	ssp_pkg::parse_state_t st_nxt;
	logic                  v_s2;
	ssp_pkg::parse_state_t snap_s2;
	logic                  out_valid_q;
	logic [63:0]           value_q;
	logic                  ok_q;
	logic [63:0]           fin_value;
	logic                  fin_ok;

	// Advance the pipeline unless a result is stalled
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en || !v_s1;

	ssp_step u_step (
		.st        (st_q),
		.char_code (char_s1),
		.nxt       (st_nxt)
	);

	ssp_finish u_finish (
		.st         (snap_s2),
		.size_value (fin_value),
		.size_ok    (fin_ok)
	);

	// Control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= ssp_pkg::STATE_RESET;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (en) begin
				v_s2        <= v_s1 && last_s1;
				out_valid_q <= v_s2;
				if (v_s1) begin
					st_q <= last_s1 ? ssp_pkg::STATE_RESET : st_nxt;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
		if (en) begin
			snap_s2 <= st_nxt;
			value_q <= fin_value;
			ok_q    <= fin_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign size_value = value_q;
	assign size_ok    = ok_q;

endmodule

[design/ssp_step.sv]
module ssp_step (
	input  ssp_pkg::parse_state_t st,
	input  logic [7:0]            char_code,
	output ssp_pkg::parse_state_t nxt
);

	logic        sp;
	logic        dg;
	logic [7:0]  low;
	logic [67:0] acc_ext;
	logic [67:0] mac;

	// Classify the character
	assign sp  = (char_code == ssp_pkg::CH_SPACE) ||
		((char_code >= ssp_pkg::CH_TAB) && (char_code <= ssp_pkg::CH_CR));
	assign dg  = (char_code >= ssp_pkg::CH_ZERO) && (char_code <= ssp_pkg::CH_NINE);
	assign low = ((char_code >= ssp_pkg::CH_UP_A) && (char_code <= ssp_pkg::CH_UP_Z)) ?
		(char_code + 8'd32) : char_code;

	// Times ten plus digit, with room to see overflow
	assign acc_ext = {4'd0, st.acc};
	assign mac     = (acc_ext << 3) + (acc_ext << 1) + {64'd0, char_code[3:0]};

	// Advance the parse state by one character
	always_comb begin
		nxt = st;
		if (!st.err) begin
			unique case (st.phase)
				ssp_pkg::PH_LEAD: begin
					if (sp) begin
						nxt = st;
					end else if (dg) begin
						nxt.acc   = {60'd0, char_code[3:0]};
						nxt.phase = ssp_pkg::PH_DIGITS;
					end else begin
						nxt.err = 1'b1;
					end
				end
				ssp_pkg::PH_DIGITS,
				ssp_pkg::PH_SUFFIX: begin
					if (dg && (st.phase == ssp_pkg::PH_DIGITS)) begin
						if (mac[67:64] != 4'd0) begin
							nxt.err = 1'b1;
						end else begin
							nxt.acc = mac[63:0];
						end
					end else if (sp) begin
						nxt.phase = ssp_pkg::PH_TRAIL;
					end else begin
						nxt.phase = ssp_pkg::PH_SUFFIX;
						unique case (st.sfx_len)
							2'd0: begin
								nxt.sfx0    = low;
								nxt.sfx_len = 2'd1;
							end
							2'd1: begin
								nxt.sfx1    = low;
								nxt.sfx_len = 2'd2;
							end
							default: nxt.err = 1'b1;
						endcase
					end
				end
				default: begin
					if (!sp) begin
						nxt.err = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

[design/ssp_finish.sv]
module ssp_finish (
	input  ssp_pkg::parse_state_t st,
	output logic [63:0]           size_value,
	output logic                  size_ok
);

	logic       valid_sfx;
	logic       long_ok;
	logic [2:0] unit;
	logic       fits;
	logic [63:0] shifted;

	// Unit select: 0 bytes, 1 kilo, 2 mega, 3 giga, 4 tera
	always_comb begin
		unit      = 3'd0;
		valid_sfx = 1'b0;
		long_ok   = (st.sfx_len == 2'd1) ||
			((st.sfx_len == 2'd2) && ((st.sfx1 == ssp_pkg::CH_B) || (st.sfx1 == ssp_pkg::CH_I)));
		if (st.sfx_len == 2'd0) begin
			valid_sfx = 1'b1;
		end else if ((st.sfx_len == 2'd1) && (st.sfx0 == ssp_pkg::CH_B)) begin
			valid_sfx = 1'b1;
		end else begin
			unique case (st.sfx0)
				ssp_pkg::CH_K: begin unit = 3'd1; valid_sfx = long_ok; end
				ssp_pkg::CH_M: begin unit = 3'd2; valid_sfx = long_ok; end
				ssp_pkg::CH_G: begin unit = 3'd3; valid_sfx = long_ok; end
				ssp_pkg::CH_T: begin unit = 3'd4; valid_sfx = long_ok; end
				default: valid_sfx = 1'b0;
			endcase
		end
	end

	// Check headroom and apply the shift
	always_comb begin
		unique case (unit)
			3'd1: begin
				fits    = (st.acc[63:64-ssp_pkg::SHIFT_K] == '0);
				shifted = st.acc << ssp_pkg::SHIFT_K;
			end
			3'd2: begin
				fits    = (st.acc[63:64-ssp_pkg::SHIFT_M] == '0);
				shifted = st.acc << ssp_pkg::SHIFT_M;
			end
			3'd3: begin
				fits    = (st.acc[63:64-ssp_pkg::SHIFT_G] == '0);
				shifted = st.acc << ssp_pkg::SHIFT_G;
			end
			3'd4: begin
				fits    = (st.acc[63:64-ssp_pkg::SHIFT_T] == '0);
				shifted = st.acc << ssp_pkg::SHIFT_T;
			end
			default: begin
				fits    = 1'b1;
				shifted = st.acc;
			end
		endcase
	end

	assign size_ok    = !st.err && (st.phase != ssp_pkg::PH_LEAD) && valid_sfx && fits;
	assign size_value = size_ok ? shifted : 64'd0;

endmodule

[design/ssp_checker.sv]
module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  char_code,
	input logic        last_char,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] size_value,
	input logic        size_ok
);

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(size_value) && $stable(size_ok))
		else $error("result beat changed while stalled");

	// Drop the value to zero on a failed parse
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !size_ok |-> size_value == 64'd0)
		else $error("failed parse carries a non-zero value");

	// Backpressure reaches the input only through a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// Leave reset with no result pending
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result beat present straight after reset");

endmodule

bind size_string_parser ssp_checker u_ssp_checker (.*);
